### rtl/bfs_pkg.sv
// shared types, constants and helpers for the breadth-first search engine
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none
package bfs_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;

   localparam int VW  = $clog2(MAX_VERTICES);   // vertex index width
   localparam int VCW = VW + 1;                  // vertex count width
   localparam int EW  = $clog2(MAX_EDGES);      // edge index width
   localparam int ECW = EW + 1;                  // edge count width
   localparam int DW  = 6;                       // distance field width

   typedef logic [VW-1:0]  vidx_type;
   typedef logic [VCW-1:0] vcnt_type;
   typedef logic [EW-1:0]  eidx_type;
   typedef logic [ECW-1:0] ecnt_type;
   typedef logic [DW-1:0]  dist_type;

   // operation codes of a request
   localparam logic [1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [1:0] OP_SEARCH   = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   typedef enum logic [2:0] {
      STAT_STORED  = 3'd0,
      STAT_DROPPED = 3'd1,
      STAT_CLEARED = 3'd2,
      STAT_VISITED = 3'd3,
      STAT_BAD_SRC = 3'd4
   } status_type;

   typedef struct packed {
      logic     has_next;
      eidx_type next;
   } link_type;

   typedef struct packed {
      dist_type distance;
      vidx_type parent;
   } dist_par_type;

   typedef struct packed {
      status_type status;
      vidx_type   vertex;
      dist_type   distance;
      vidx_type   parent;
      logic       has_parent;
      logic       last;
   } result_type;

   // graph store commands and read data
   typedef struct packed {
      vidx_type vaddr;
      logic     head_wr;
      logic     tail_wr;
      eidx_type list_wdata;
      logic     ne_set;
      logic     ne_clear_all;
      eidx_type eaddr;
      logic     tgt_wr;
      vidx_type tgt_wdata;
      logic     link_wr;
      link_type link_wdata;
   } graph_cmd_type;

   typedef struct packed {
      eidx_type head_rd;
      eidx_type tail_rd;
      logic     ne_rd;
      vidx_type tgt_rd;
      link_type link_rd;
   } graph_rd_type;

   // visit store commands and read data
   typedef struct packed {
      logic         vis_clear_all;
      logic         vis_set;
      vidx_type     vis_addr;
      vidx_type     dp_addr;
      logic         dp_wr;
      dist_par_type dp_wdata;
      logic         q_wr;
      vidx_type     q_waddr;
      vidx_type     q_wdata;
      vidx_type     q_raddr;
   } visit_cmd_type;

   typedef struct packed {
      logic         vis_hit;
      dist_par_type dp_rd;
      vidx_type     q_rd;
   } visit_rd_type;

   // index below the configured vertex count; a count above the store saturates
   function automatic logic in_range(input vidx_type v, input vcnt_type vc);
      return {1'b0, v} < vc;
   endfunction

endpackage
`default_nettype wire

### rtl/bfs_req_if.sv
// request channel: operation and two vertex operands
// depends on bfs_pkg
`timescale 1ns / 1ps
`default_nettype none
interface bfs_req_if;
   import bfs_pkg::*;
   logic     valid;
   logic     ready;
   logic [1:0] operation;
   vidx_type first_vertex;
   vidx_type second_vertex;
   modport source (output valid, operation, first_vertex, second_vertex, input ready);
   modport sink   (input valid, operation, first_vertex, second_vertex, output ready);
endinterface
`default_nettype wire

### rtl/bfs_rsp_if.sv
// result channel: status, reached vertex, distance, parent and last flag
// depends on bfs_pkg
`timescale 1ns / 1ps
`default_nettype none
interface bfs_rsp_if;
   import bfs_pkg::*;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   vidx_type   vertex;
   dist_type   distance;
   vidx_type   parent;
   logic       has_parent;
   logic       last;
   modport source (output valid, status, vertex, distance, parent, has_parent, last,
                   input ready);
   modport sink   (input valid, status, vertex, distance, parent, has_parent, last,
                   output ready);
endinterface
`default_nettype wire

### rtl/bfs_csr_if.sv
// configuration write channel for the vertex count register
// depends on bfs_pkg
`timescale 1ns / 1ps
`default_nettype none
interface bfs_csr_if;
   import bfs_pkg::*;
   logic     valid;
   logic     ready;
   vcnt_type vertex_count;
   modport source (output valid, vertex_count, input ready);
   modport sink   (input valid, vertex_count, output ready);
endinterface
`default_nettype wire

### rtl/bfs_graph_store.sv
// adjacency storage: per-vertex list head/tail memories with valid bits,
// edge target and link memories; depends on bfs_pkg
`timescale 1ns / 1ps
`default_nettype none
module bfs_graph_store (
   input  wire                     clock,
   input  wire                     reset,
   input  bfs_pkg::graph_cmd_type  cmd,
   output bfs_pkg::graph_rd_type   rd
);
   import bfs_pkg::*;

   eidx_type head_mem [MAX_VERTICES];
   eidx_type tail_mem [MAX_VERTICES];
   vidx_type tgt_mem  [MAX_EDGES];
   link_type link_mem [MAX_EDGES];

   logic [MAX_VERTICES-1:0] ne_ff, ne_in;
   eidx_type head_rd_ff, tail_rd_ff;
   logic     ne_rd_ff;
   vidx_type tgt_rd_ff;
   link_type link_rd_ff;

   always_comb begin
      ne_in = ne_ff;
      if (cmd.ne_clear_all) begin
         ne_in = '0;
      end
      if (cmd.ne_set) begin
         ne_in[cmd.vaddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ne_ff <= '0;
      end else begin
         ne_ff <= ne_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.head_wr) begin
         head_mem[cmd.vaddr] <= cmd.list_wdata;
      end
      if (cmd.tail_wr) begin
         tail_mem[cmd.vaddr] <= cmd.list_wdata;
      end
      head_rd_ff <= head_mem[cmd.vaddr];
      tail_rd_ff <= tail_mem[cmd.vaddr];
      ne_rd_ff   <= ne_ff[cmd.vaddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.tgt_wr) begin
         tgt_mem[cmd.eaddr] <= cmd.tgt_wdata;
      end
      if (cmd.link_wr) begin
         link_mem[cmd.eaddr] <= cmd.link_wdata;
      end
      tgt_rd_ff  <= tgt_mem[cmd.eaddr];
      link_rd_ff <= link_mem[cmd.eaddr];
   end

   assign rd.head_rd = head_rd_ff;
   assign rd.tail_rd = tail_rd_ff;
   assign rd.ne_rd   = ne_rd_ff;
   assign rd.tgt_rd  = tgt_rd_ff;
   assign rd.link_rd = link_rd_ff;

endmodule
`default_nettype wire

### rtl/bfs_visit_store.sv
// search-time storage: visited bits, distance/parent memory, visit queue
// depends on bfs_pkg
`timescale 1ns / 1ps
`default_nettype none
module bfs_visit_store (
   input  wire                     clock,
   input  wire                     reset,
   input  bfs_pkg::visit_cmd_type  cmd,
   output bfs_pkg::visit_rd_type   rd
);
   import bfs_pkg::*;

   dist_par_type dp_mem [MAX_VERTICES];
   vidx_type     q_mem  [MAX_VERTICES];

   logic [MAX_VERTICES-1:0] vis_ff, vis_in;
   dist_par_type dp_rd_ff;
   vidx_type     q_rd_ff;

   always_comb begin
      vis_in = vis_ff;
      if (cmd.vis_clear_all) begin
         vis_in = '0;
      end
      if (cmd.vis_set) begin
         vis_in[cmd.vis_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff <= '0;
      end else begin
         vis_ff <= vis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dp_wr) begin
         dp_mem[cmd.dp_addr] <= cmd.dp_wdata;
      end
      dp_rd_ff <= dp_mem[cmd.dp_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.q_wr) begin
         q_mem[cmd.q_waddr] <= cmd.q_wdata;
      end
      q_rd_ff <= q_mem[cmd.q_raddr];
   end

   assign rd.vis_hit = vis_ff[cmd.vis_addr];
   assign rd.dp_rd   = dp_rd_ff;
   assign rd.q_rd    = q_rd_ff;

endmodule
`default_nettype wire

### rtl/bfs_ctrl.sv
// sequencer: decodes requests, appends edges and walks the search loop
// one step at a time over the graph and visit stores; depends on bfs_pkg
`timescale 1ns / 1ps
`default_nettype none
module bfs_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [1:0]              req_operation,
   input  bfs_pkg::vidx_type       req_first,
   input  bfs_pkg::vidx_type       req_second,
   input  bfs_pkg::vcnt_type       vertex_count,
   output bfs_pkg::graph_cmd_type  gcmd,
   input  bfs_pkg::graph_rd_type   grd,
   output bfs_pkg::visit_cmd_type  vcmd,
   input  bfs_pkg::visit_rd_type   vrd,
   output logic                    emit_valid,
   input  wire                     emit_ready,
   output bfs_pkg::result_type     emit_res
);
   import bfs_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DECODE = 10'b00_0000_0010,
      S_ADD2   = 10'b00_0000_0100,
      S_DEQ    = 10'b00_0000_1000,
      S_VREAD  = 10'b00_0001_0000,
      S_VWAIT  = 10'b00_0010_0000,
      S_EREAD  = 10'b00_0100_0000,
      S_ECHECK = 10'b00_1000_0000,
      S_FIN    = 10'b01_0000_0000,
      S_EMIT   = 10'b10_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   vidx_type   a_ff, a_in, b_ff, b_in;
   ecnt_type   used_ff, used_in;
   vcnt_type   rptr_ff, rptr_in, wptr_ff, wptr_in;
   vidx_type   cur_ff, cur_in, cur_par_ff, cur_par_in;
   dist_type   cur_dist_ff, cur_dist_in;
   eidx_type   edge_ff, edge_in;
   result_type res_ff, res_in;
   logic       discover;

   assign req_ready  = (state_ff == S_IDLE);
   assign emit_valid = (state_ff == S_EMIT);
   assign emit_res   = res_ff;

   assign discover = in_range(grd.tgt_rd, vertex_count) && !vrd.vis_hit &&
                     (wptr_ff < vcnt_type'(MAX_VERTICES));

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      used_in     = used_ff;
      rptr_in     = rptr_ff;
      wptr_in     = wptr_ff;
      cur_in      = cur_ff;
      cur_dist_in = cur_dist_ff;
      cur_par_in  = cur_par_ff;
      edge_in     = edge_ff;
      res_in      = res_ff;

      gcmd              = '0;
      gcmd.vaddr        = a_ff;
      gcmd.eaddr        = edge_ff;
      gcmd.list_wdata   = used_ff[EW-1:0];
      gcmd.tgt_wdata    = b_ff;

      vcmd              = '0;
      vcmd.vis_addr     = grd.tgt_rd;
      vcmd.dp_addr      = grd.tgt_rd;
      vcmd.dp_wdata     = '{distance: cur_dist_ff + dist_type'(1), parent: cur_ff};
      vcmd.q_waddr      = wptr_ff[VW-1:0];
      vcmd.q_wdata      = grd.tgt_rd;
      vcmd.q_raddr      = rptr_ff[VW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               a_in     = req_first;
               b_in     = req_second;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in = '{status: STAT_STORED, vertex: '0, distance: '0, parent: '0,
                       has_parent: 1'b0, last: 1'b1};
            unique case (op_ff)
               OP_ADD_EDGE: begin
                  if (in_range(a_ff, vertex_count) && in_range(b_ff, vertex_count) &&
                      used_ff != ecnt_type'(MAX_EDGES)) begin
                     // new edge ends its list; tail of the origin read meanwhile
                     gcmd.eaddr      = used_ff[EW-1:0];
                     gcmd.tgt_wr     = 1'b1;
                     gcmd.link_wr    = 1'b1;
                     gcmd.link_wdata = '0;
                     state_in        = S_ADD2;
                  end else begin
                     res_in.status = STAT_DROPPED;
                     state_in      = S_EMIT;
                  end
               end
               OP_SEARCH: begin
                  if (in_range(a_ff, vertex_count)) begin
                     vcmd.vis_clear_all = 1'b1;
                     vcmd.vis_set       = 1'b1;
                     vcmd.vis_addr      = a_ff;
                     vcmd.dp_wr         = 1'b1;
                     vcmd.dp_addr       = a_ff;
                     vcmd.dp_wdata      = '0;
                     vcmd.q_wr          = 1'b1;
                     vcmd.q_waddr       = '0;
                     vcmd.q_wdata       = a_ff;
                     rptr_in            = '0;
                     wptr_in            = vcnt_type'(1);
                     state_in           = S_DEQ;
                  end else begin
                     res_in.status = STAT_BAD_SRC;
                     state_in      = S_EMIT;
                  end
               end
               OP_CLEAR: begin
                  gcmd.ne_clear_all = 1'b1;
                  used_in           = '0;
                  res_in.status     = STAT_CLEARED;
                  state_in          = S_EMIT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_ADD2: begin
            if (grd.ne_rd) begin
               gcmd.eaddr      = grd.tail_rd;
               gcmd.link_wr    = 1'b1;
               gcmd.link_wdata = '{has_next: 1'b1, next: used_ff[EW-1:0]};
            end else begin
               gcmd.head_wr = 1'b1;
               gcmd.ne_set  = 1'b1;
            end
            gcmd.tail_wr = 1'b1;
            used_in      = used_ff + ecnt_type'(1);
            state_in     = S_EMIT;
         end
         S_DEQ: begin
            rptr_in  = rptr_ff + vcnt_type'(1);
            state_in = S_VREAD;
         end
         S_VREAD: begin
            cur_in       = vrd.q_rd;
            gcmd.vaddr   = vrd.q_rd;
            vcmd.dp_addr = vrd.q_rd;
            state_in     = S_VWAIT;
         end
         S_VWAIT: begin
            cur_dist_in = vrd.dp_rd.distance;
            cur_par_in  = vrd.dp_rd.parent;
            edge_in     = grd.head_rd;
            state_in    = grd.ne_rd ? S_EREAD : S_FIN;
         end
         S_EREAD: begin
            state_in = S_ECHECK;
         end
         S_ECHECK: begin
            if (discover) begin
               vcmd.vis_set = 1'b1;
               vcmd.dp_wr   = 1'b1;
               vcmd.q_wr    = 1'b1;
               wptr_in      = wptr_ff + vcnt_type'(1);
            end
            if (grd.link_rd.has_next) begin
               edge_in  = grd.link_rd.next;
               state_in = S_EREAD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in = '{status: STAT_VISITED, vertex: cur_ff, distance: cur_dist_ff,
                       parent: cur_par_ff, has_parent: (cur_ff != a_ff),
                       last: (rptr_ff == wptr_ff)};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_ready) begin
               state_in = res_ff.last ? S_IDLE : S_DEQ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         rptr_ff  <= '0;
         wptr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_ff      <= cur_in;
      cur_dist_ff <= cur_dist_in;
      cur_par_ff  <= cur_par_in;
      edge_ff     <= edge_in;
      res_ff      <= res_in;
   end

endmodule
`default_nettype wire

### rtl/breadth_first_search_engine.sv
// breadth-first search engine top level: vertex count register, result register
// depends on bfs_pkg, bfs_req_if, bfs_rsp_if, bfs_csr_if, bfs_graph_store,
// bfs_visit_store and bfs_ctrl
// add edge: decode writes target and link, a second step links the edge into its list
// search: setup, then dequeue, read, wait, finish per vertex; read, check per edge
// one request at a time, taken the cycle after its predecessor's last result leaves
// the sequencer; clear, drop and bad source go from decode straight to the result
// reset: synchronous; vertex count 64, all lists empty via per-vertex valid bits,
// edge and vertex memories are not cleared (never read before written)
`timescale 1ns / 1ps
`default_nettype none
module breadth_first_search_engine (
   input  wire        clock,
   input  wire        reset,
   bfs_req_if.sink    req_chan,
   bfs_rsp_if.source  rsp_chan,
   bfs_csr_if.sink    csr_chan
);
   import bfs_pkg::*;

   // vertex count register, written on any csr transfer
   vcnt_type vcount_ff;

   // result register between the sequencer and the result channel
   logic       rsp_valid_ff;
   result_type rsp_res_ff;

   // store interfaces
   graph_cmd_type gcmd;
   graph_rd_type  grd;
   visit_cmd_type vcmd;
   visit_rd_type  vrd;

   // sequencer result handoff
   logic       emit_valid;
   logic       emit_ready;
   result_type emit_res;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= vcnt_type'(MAX_VERTICES);
      end else if (csr_chan.valid) begin
         vcount_ff <= csr_chan.vertex_count;
      end
   end

   // result register can load when empty or when its transfer happens now
   assign emit_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_ready) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ready && emit_valid) begin
         rsp_res_ff <= emit_res;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_res_ff.status;
   assign rsp_chan.vertex     = rsp_res_ff.vertex;
   assign rsp_chan.distance   = rsp_res_ff.distance;
   assign rsp_chan.parent     = rsp_res_ff.parent;
   assign rsp_chan.has_parent = rsp_res_ff.has_parent;
   assign rsp_chan.last       = rsp_res_ff.last;

   // sequencer drives both stores one step per cycle, holding while a result waits to load
   bfs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_operation (req_chan.operation),
      .req_first     (req_chan.first_vertex),
      .req_second    (req_chan.second_vertex),
      .vertex_count  (vcount_ff),
      .gcmd          (gcmd),
      .grd           (grd),
      .vcmd          (vcmd),
      .vrd           (vrd),
      .emit_valid    (emit_valid),
      .emit_ready    (emit_ready),
      .emit_res      (emit_res)
   );

   // adjacency lists
   bfs_graph_store u_graph (
      .clock (clock),
      .reset (reset),
      .cmd   (gcmd),
      .rd    (grd)
   );

   // visited bits, distances, parents and the visit queue
   bfs_visit_store u_visit (
      .clock (clock),
      .reset (reset),
      .cmd   (vcmd),
      .rd    (vrd)
   );

endmodule
`default_nettype wire
